// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mtbb_pkg.sv =====
// Shared constants and types of the morph target blend and bounds block.
`timescale 1ns / 1ps
`default_nettype none

package mtbb_pkg;

  // Number of morph targets and coordinate width
  localparam int NUM_TARGETS = 4;
  localparam int COORD_WIDTH = 32;

  // Weights: Q2.14, one is 2^14
  localparam int WEIGHT_W   = 16;
  localparam int WEFF_W     = 15;
  localparam int FRAC_SHIFT = 14;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = 16'sd16384;

  // Product of a delta and a clamped weight, and the exact blend sum
  localparam int PROD_W = COORD_WIDTH + WEFF_W + 1;
  localparam int SUM_W  = COORD_WIDTH + FRAC_SHIFT + 5;
  localparam int RND_W  = SUM_W - FRAC_SHIFT;

  // Stream side fields
  localparam int AXIS_W    = 2;
  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 3;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  // Saturation bounds of a coordinate
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT0 = 3'd0,
    REG_WEIGHT1 = 3'd1,
    REG_WEIGHT2 = 3'd2,
    REG_WEIGHT3 = 3'd3,
    REG_ACTIVE  = 3'd4
  } cfg_reg_t;

  typedef logic [NUM_TARGETS-1:0][WEFF_W-1:0]      weff_vec_t;
  typedef logic [NUM_TARGETS-1:0][COORD_WIDTH-1:0] delta_vec_t;

  // Blended coordinate handed to the bounds stage
  typedef struct packed {
    logic [AXIS_W-1:0]      axis;
    logic                   restart;
    logic [COORD_WIDTH-1:0] coord;
    logic                   sat;
  } blend_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/mtbb_cfg.sv =====
// Configuration registers and the effective (clamped) weight of each target.
`timescale 1ns / 1ps
`default_nettype none

module mtbb_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic [mtbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mtbb_pkg::WEIGHT_W-1:0]  cfg_data,
  output mtbb_pkg::weff_vec_t                 weff
);
  import mtbb_pkg::*;

  logic [NUM_TARGETS-1:0][WEIGHT_W-1:0] weight_r;
  logic [CFG_IDX_W-1:0]                 active_r;
  logic [CFG_IDX_W-1:0]                 n_used;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
      active_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WEIGHT0: weight_r[0] <= cfg_data;
        REG_WEIGHT1: weight_r[1] <= cfg_data;
        REG_WEIGHT2: weight_r[2] <= cfg_data;
        REG_WEIGHT3: weight_r[3] <= cfg_data;
        REG_ACTIVE:  active_r    <= cfg_data[CFG_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Count of applied targets, capped at the number of delta fields
  assign n_used = (active_r > CFG_IDX_W'(NUM_TARGETS)) ? CFG_IDX_W'(NUM_TARGETS) : active_r;

  // Skip inactive targets and non-positive weights, clamp above one
  for (genvar i = 0; i < NUM_TARGETS; i++) begin : g_weff
    always_comb begin
      if ((CFG_IDX_W'(i) >= n_used) || weight_r[i][WEIGHT_W-1] || (weight_r[i] == '0)) begin
        weff[i] = '0;
      end else if ($signed(weight_r[i]) > WEIGHT_ONE) begin
        weff[i] = WEIGHT_ONE[WEFF_W-1:0];
      end else begin
        weff[i] = weight_r[i][WEFF_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mtbb_blend.sv =====
// Blend pipeline: input register, product register, rounded and saturated sum.
`timescale 1ns / 1ps
`default_nettype none

module mtbb_blend (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mtbb_pkg::AXIS_W-1:0]      in_axis,
  input  wire logic                             in_restart,
  input  wire logic [mtbb_pkg::COORD_WIDTH-1:0] in_base,
  input  wire mtbb_pkg::delta_vec_t             in_delta,
  input  wire mtbb_pkg::weff_vec_t              weff,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output mtbb_pkg::blend_res_t                  res
);
  import mtbb_pkg::*;

  // Stage 1: input register
  logic                   v1_r;
  logic [AXIS_W-1:0]      axis1_r;
  logic                   restart1_r;
  logic [COORD_WIDTH-1:0] base1_r;
  delta_vec_t             delta1_r;

  // Stage 2: products
  logic                                 v2_r;
  logic [AXIS_W-1:0]                    axis2_r;
  logic                                 restart2_r;
  logic [COORD_WIDTH-1:0]               base2_r;
  logic [NUM_TARGETS-1:0][PROD_W-1:0]   prod2_r;
  logic [NUM_TARGETS-1:0][PROD_W-1:0]   prod2_nxt;

  // Stage 3: blended coordinate
  logic       v3_r;
  blend_res_t res3_r;
  blend_res_t res3_nxt;

  logic ready1, ready2, ready3;

  assign ready3   = !v3_r || res_ready;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_ready = ready1;

  // Valid bits per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      axis1_r    <= in_axis;
      restart1_r <= in_restart;
      base1_r    <= in_base;
      delta1_r   <= in_delta;
    end
  end

  // One multiplier per target: signed delta times unsigned clamped weight
  for (genvar i = 0; i < NUM_TARGETS; i++) begin : g_mul
    logic signed [COORD_WIDTH-1:0] d_s;
    logic signed [WEFF_W:0]        w_s;
    logic signed [PROD_W-1:0]      p_s;
    assign d_s = $signed(delta1_r[i]);
    assign w_s = $signed({1'b0, weff[i]});
    // full-width product: operands are sign-extended to PROD_W first
    assign p_s = d_s * w_s;
    assign prod2_nxt[i] = p_s;
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1_r) begin
      axis2_r    <= axis1_r;
      restart2_r <= restart1_r;
      base2_r    <= base1_r;
      prod2_r    <= prod2_nxt;
    end
  end

  // Exact sum in Q.30, round half up, saturate
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_rnd;
  logic signed [RND_W-1:0] rnd;
  logic                    ovf;

  always_comb begin
    sum = $signed({{(SUM_W-COORD_WIDTH-FRAC_SHIFT){base2_r[COORD_WIDTH-1]}},
                   base2_r, {FRAC_SHIFT{1'b0}}});
    for (int i = 0; i < NUM_TARGETS; i++) begin
      sum = sum + SUM_W'($signed(prod2_r[i]));
    end
    sum_rnd = sum + $signed(SUM_W'(1) <<< (FRAC_SHIFT - 1));
    rnd     = sum_rnd[SUM_W-1:FRAC_SHIFT];
    // Out of range when the bits above the coordinate are not all the sign
    ovf = (rnd[RND_W-1:COORD_WIDTH-1] != {(RND_W-COORD_WIDTH+1){1'b0}}) &&
          (rnd[RND_W-1:COORD_WIDTH-1] != {(RND_W-COORD_WIDTH+1){1'b1}});

    res3_nxt.axis    = axis2_r;
    res3_nxt.restart = restart2_r;
    res3_nxt.sat     = ovf;
    if (!ovf) begin
      res3_nxt.coord = rnd[COORD_WIDTH-1:0];
    end else if (rnd[RND_W-1]) begin
      res3_nxt.coord = COORD_MIN;
    end else begin
      res3_nxt.coord = COORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2_r) begin
      res3_r <= res3_nxt;
    end
  end

  assign res_valid = v3_r;
  assign res       = res3_r;

endmodule

`default_nettype wire

// ===== rtl/core/mtbb_bounds.sv =====
// Running bounding box per axis and the result register.
`timescale 1ns / 1ps
`default_nettype none

module mtbb_bounds (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             res_valid,
  output logic                                  res_ready,
  input  wire mtbb_pkg::blend_res_t             res,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mtbb_pkg::COORD_WIDTH-1:0]      out_coord,
  output logic [mtbb_pkg::AXIS_W-1:0]           out_axis,
  output logic [mtbb_pkg::COORD_WIDTH-1:0]      out_min,
  output logic [mtbb_pkg::COORD_WIDTH-1:0]      out_max,
  output logic                                  out_sat
);
  import mtbb_pkg::*;

  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] box_min_r, box_min_nxt;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] box_max_r, box_max_nxt;
  logic                                 out_valid_r;
  logic [COORD_WIDTH-1:0]               coord_r, min_r, max_r;
  logic [AXIS_W-1:0]                    axis_r;
  logic                                 sat_r;
  logic [COORD_WIDTH-1:0]               min_nxt, max_nxt;
  logic [COORD_WIDTH-1:0]               cur_min, cur_max;
  logic                                 load;

  assign res_ready = !out_valid_r || out_ready;
  assign load      = res_valid && res_ready;

  // Box update: restart clears all axes, then the item's axis (unless it is axis three) folds in the coordinate
  always_comb begin
    box_min_nxt = box_min_r;
    box_max_nxt = box_max_r;
    if (res.restart) begin
      box_min_nxt = {NUM_AXES{COORD_MAX}};
      box_max_nxt = {NUM_AXES{COORD_MIN}};
    end
    cur_min = '0;
    cur_max = '0;
    min_nxt = '0;
    max_nxt = '0;
    if (res.axis != AXIS_NONE) begin
      cur_min = box_min_nxt[res.axis];
      cur_max = box_max_nxt[res.axis];
      min_nxt = ($signed(res.coord) < $signed(cur_min)) ? res.coord : cur_min;
      max_nxt = ($signed(res.coord) > $signed(cur_max)) ? res.coord : cur_max;
      box_min_nxt[res.axis] = min_nxt;
      box_max_nxt[res.axis] = max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_r   <= {NUM_AXES{COORD_MAX}};
      box_max_r   <= {NUM_AXES{COORD_MIN}};
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        box_min_r <= box_min_nxt;
        box_max_r <= box_max_nxt;
      end
      if (res_ready) out_valid_r <= res_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      coord_r <= res.coord;
      axis_r  <= res.axis;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sat_r   <= res.sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_coord = coord_r;
  assign out_axis  = axis_r;
  assign out_min   = min_r;
  assign out_max   = max_r;
  assign out_sat   = sat_r;

endmodule

`default_nettype wire

// ===== rtl/core/morph_target_blend_bounds.sv =====
// Top level of the morph target blend with running bounding box.
`timescale 1ns / 1ps
`default_nettype none

// Takes one vertex coordinate component per transfer, adds delta times
// clamped weight for each active morph target (weights at or below zero are
// skipped, above one count as one), rounds the Q.30 sum to Q16.16 and
// saturates it, then folds it into a running min/max box for its axis.
// One item per clock is accepted unless out_tready stalls the pipeline; the
// result passes the input register, multiplier register, sum/saturate
// register and the output register where the box is updated.
// Each stage has its own valid, so input is taken while a result waits as
// long as a stage is free. The user must write weights and active_targets
// over the cfg port only while no item is in flight; the block itself does
// not enforce it. cfg_ready is always high.
module morph_target_blend_bounds (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // base_coord[31:0], delta_zero[63:32], delta_one[95:64],
  // delta_two[127:96], delta_three[159:128]
  input  wire logic [159:0] in_tdata,
  // axis[1:0], restart_bounds[2]
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // morphed_coord[31:0], bound_min[63:32], bound_max[95:64]
  output logic [95:0]       out_tdata,
  // out_axis[1:0], saturated[2]
  output logic [2:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import mtbb_pkg::*;

  weff_vec_t              weff;
  delta_vec_t             in_delta;
  blend_res_t             res;
  logic                   res_valid, res_ready;
  logic [COORD_WIDTH-1:0] out_coord, out_min, out_max;
  logic [AXIS_W-1:0]      out_axis;
  logic                   out_sat;

  assign cfg_ready = 1'b1;

  // Unpack the delta fields
  for (genvar i = 0; i < NUM_TARGETS; i++) begin : g_delta
    assign in_delta[i] = in_tdata[COORD_WIDTH*(i+2)-1 -: COORD_WIDTH];
  end

  mtbb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .weff      (weff)
  );

  mtbb_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_axis    (in_tuser[1:0]),
    .in_restart (in_tuser[2]),
    .in_base    (in_tdata[COORD_WIDTH-1:0]),
    .in_delta   (in_delta),
    .weff       (weff),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  mtbb_bounds u_bounds (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_coord (out_coord),
    .out_axis  (out_axis),
    .out_min   (out_min),
    .out_max   (out_max),
    .out_sat   (out_sat)
  );

  assign out_tdata = {out_max, out_min, out_coord};
  assign out_tuser = {out_sat, out_axis};

endmodule

`default_nettype wire

// ===== rtl/core/mtbb_checker.sv =====
// Port-level checks of the morph target blend block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mtbb_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [95:0]  out_tdata,
  input wire logic [2:0]   out_tuser
);
  import mtbb_pkg::*;

  logic signed [COORD_WIDTH-1:0] chk_coord, chk_min, chk_max;
  logic [AXIS_W-1:0]             chk_axis;
  logic                          chk_sat;
  logic                          box_ok;
  logic                          at_limit;

  // Result fields as seen on the ports
  assign chk_coord = out_tdata[31:0];
  assign chk_min   = out_tdata[63:32];
  assign chk_max   = out_tdata[95:64];
  assign chk_axis  = out_tuser[1:0];
  assign chk_sat   = out_tuser[2];
  assign box_ok    = (chk_min <= chk_coord) && (chk_coord <= chk_max);
  assign at_limit  = (out_tdata[31:0] == COORD_MAX) || (out_tdata[31:0] == COORD_MIN);

  // A stalled result stays offered
  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // The box on a real axis always contains the coordinate just taken in
  `ASSERT_CLK(a_box_holds, out_tvalid && (chk_axis != AXIS_NONE) |-> box_ok, "coord outside box")

  // Axis three reports zero bounds
  `ASSERT_CLK(a_axis3_zero, out_tvalid && (chk_axis == AXIS_NONE) |-> (out_tdata[95:32] == '0), "bounds nonzero")

  // A saturated coordinate sits on a range limit
  `ASSERT_CLK(a_sat_limit, out_tvalid && chk_sat |-> at_limit, "saturated value not at a limit")

  // Reset empties the result register
  `ASSERT_CLK_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind morph_target_blend_bounds mtbb_checker u_mtbb_checker (.*);

`default_nettype wire
